// ===== hdl/tc_pkg.sv =====
// ----------------------------------------------------------------------------
// tc_pkg
// Shared sizes, types and helpers for the triangle counter: vertex index and
// row widths, the controller/datapath command and status bundles, popcount.
// ----------------------------------------------------------------------------
package tc_pkg;

    // Graph size and derived widths
    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int ROW_W        = MAX_VERTICES;
    localparam int IN_VW        = 6;
    localparam int COUNT_W      = 16;
    localparam int PC_W         = $clog2(ROW_W + 1);

    typedef logic [VIDX_W-1:0]  vidx_t;
    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [PC_W-1:0]    pcnt_t;

    localparam vidx_t LAST_V = vidx_t'(MAX_VERTICES - 1);

    // Controller to datapath
    typedef struct packed {
        logic  edge_load;     // an edge transfer happens this cycle
        logic  rd_from_edge;  // RAM read address comes from the incoming edge
        vidx_t rd_addr;       // RAM read address during the count pass
        logic  row_a_load;    // capture the outer row from RAM read data
        logic  scan_issue;    // a row b read was issued this cycle
        logic  acc_clr;       // zero the triangle accumulator
        logic  out_load;      // move the accumulator into the output register
        logic  clear;         // drop the whole adjacency matrix
    } tc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;      // count pipeline still holds work
        logic out_free;       // output register can take a new result
    } tc_sts_t;

    // Map a port vertex onto the internal index width
    function automatic vidx_t to_vidx(input logic [IN_VW-1:0] v);
        return vidx_t'(v);
    endfunction

    // True when the vertex names a row of the matrix
    function automatic logic in_range(input logic [IN_VW-1:0] v);
        return (32'(v) < MAX_VERTICES);
    endfunction

    // Number of set bits in one row
    function automatic pcnt_t popcount(input row_t x);
        pcnt_t n;
        n = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            n = n + pcnt_t'(x[i]);
        end
        return n;
    endfunction

endpackage

// ===== hdl/tc_ram.sv =====
// ----------------------------------------------------------------------------
// tc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. A read and a write to the same address return the old data.
// ----------------------------------------------------------------------------
module tc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/tc_datapath.sv =====
// ----------------------------------------------------------------------------
// tc_datapath
// Adjacency storage (upper triangle, one row per vertex) with a read-modify-
// write load path, and the count pipeline: row AND, popcount, accumulate.
// ----------------------------------------------------------------------------
module tc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tc_pkg::tc_cmd_t               cmd,
    output tc_pkg::tc_sts_t               sts,
    input  logic [tc_pkg::IN_VW-1:0]      vertex_a,
    input  logic [tc_pkg::IN_VW-1:0]      vertex_b,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tc_pkg::COUNT_W-1:0]    triangle_count
);

    import tc_pkg::*;

    vidx_t  va, vb, e_row, e_col, rd_addr;
    logic   e_ok;
    row_t   rd_data, rd_row, wr_data;
    logic   wr_en;

    logic   rd_vld_reg;
    row_t   valid_reg;
    logic   s1_vld_reg;
    vidx_t  s1_row_reg, s1_col_reg;
    logic   fwd_reg;
    row_t   fwd_data_reg;

    row_t   row_a_reg;
    logic   d1_vld_reg;
    vidx_t  d1_b_reg;
    row_t   and_reg;
    logic   and_vld_reg;
    count_t acc_reg;
    logic [COUNT_W:0] acc_sum;
    logic   out_vld_reg;
    count_t count_reg;

    // Decode the edge: row is the lower endpoint, column the higher one
    always_comb
    begin
        va    = to_vidx(vertex_a);
        vb    = to_vidx(vertex_b);
        e_ok  = (vertex_a != vertex_b) && in_range(vertex_a) && in_range(vertex_b);
        e_row = (va < vb) ? va : vb;
        e_col = (va < vb) ? vb : va;
    end

    assign rd_addr = cmd.rd_from_edge ? e_row : cmd.rd_addr;

    // Rows never written read as zero
    assign rd_row = rd_data & {ROW_W{rd_vld_reg}};

    // Merge the new bit into the row, forwarding the row written last cycle
    assign wr_en   = s1_vld_reg;
    assign wr_data = (fwd_reg ? fwd_data_reg : rd_row) | (row_t'(1) << s1_col_reg);

    tc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_row_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Track the load stage and row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            fwd_reg    <= 1'b0;
            rd_vld_reg <= 1'b0;
            valid_reg  <= '0;
        end
        else
        begin
            s1_vld_reg <= cmd.edge_load && e_ok;
            fwd_reg    <= s1_vld_reg && (s1_row_reg == e_row);
            rd_vld_reg <= valid_reg[rd_addr];
            if (cmd.clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[s1_row_reg] <= 1'b1;
            end
        end
    end

    // Hold load payload
    always_ff @(posedge clk)
    begin
        s1_row_reg   <= e_row;
        s1_col_reg   <= e_col;
        fwd_data_reg <= wr_data;
    end

    // Count pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_vld_reg  <= 1'b0;
            and_vld_reg <= 1'b0;
            acc_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            d1_vld_reg  <= cmd.scan_issue;
            and_vld_reg <= d1_vld_reg;
            if (cmd.acc_clr)
            begin
                acc_reg <= '0;
            end
            else if (and_vld_reg)
            begin
                acc_reg <= acc_sum[COUNT_W] ? {COUNT_W{1'b1}} : acc_sum[COUNT_W-1:0];
            end
            if (cmd.out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Saturating add of one row's common neighbors
    assign acc_sum = {1'b0, acc_reg} + (COUNT_W + 1)'(popcount(and_reg));

    // Hold count payload: common neighbors above b, only if b is adjacent to a
    always_ff @(posedge clk)
    begin
        if (cmd.row_a_load)
        begin
            row_a_reg <= rd_row;
        end
        d1_b_reg <= cmd.rd_addr;
        and_reg  <= rd_row & row_a_reg & {ROW_W{row_a_reg[d1_b_reg]}};
        if (cmd.out_load)
        begin
            count_reg <= acc_reg;
        end
    end

    assign sts.pipe_busy  = d1_vld_reg || and_vld_reg;
    assign sts.out_free   = !out_vld_reg || !out_stall;
    assign out_valid      = out_vld_reg;
    assign triangle_count = count_reg;

endmodule

// ===== hdl/tc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tc_ctrl
// Sequencer: takes edges, then walks every row a and every row b of the
// matrix, drains the count pipeline, hands off the result and clears.
// ----------------------------------------------------------------------------
module tc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            last_edge,
    input  tc_pkg::tc_sts_t sts,
    output tc_pkg::tc_cmd_t cmd
);

    import tc_pkg::*;

    localparam logic [2:0] ST_LOAD     = 3'd0;
    localparam logic [2:0] ST_DRAIN    = 3'd1;
    localparam logic [2:0] ST_ROWA     = 3'd2;
    localparam logic [2:0] ST_ROWA_LAT = 3'd3;
    localparam logic [2:0] ST_SCAN     = 3'd4;
    localparam logic [2:0] ST_FLUSH    = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0] state_reg, state_next;
    vidx_t      a_cnt_reg, a_cnt_next;
    vidx_t      b_cnt_reg, b_cnt_next;
    logic       accept;

    assign in_stall = (state_reg != ST_LOAD);
    assign accept   = in_valid && !in_stall;

    // Next state and commands
    always_comb
    begin
        state_next       = state_reg;
        a_cnt_next       = a_cnt_reg;
        b_cnt_next       = b_cnt_reg;
        cmd              = '0;
        cmd.edge_load    = accept;
        cmd.rd_from_edge = (state_reg == ST_LOAD);
        cmd.rd_addr      = b_cnt_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept && last_edge)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.acc_clr = 1'b1;
                a_cnt_next  = '0;
                state_next  = ST_ROWA;
            end
            ST_ROWA:
            begin
                cmd.rd_addr = a_cnt_reg;
                state_next  = ST_ROWA_LAT;
            end
            ST_ROWA_LAT:
            begin
                cmd.row_a_load = 1'b1;
                b_cnt_next     = '0;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                b_cnt_next     = b_cnt_reg + 1'b1;
                if (b_cnt_reg == LAST_V)
                begin
                    if (a_cnt_reg == LAST_V)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        a_cnt_next = a_cnt_reg + 1'b1;
                        state_next = ST_ROWA;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Advance state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            a_cnt_reg <= '0;
            b_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            a_cnt_reg <= a_cnt_next;
            b_cnt_reg <= b_cnt_next;
        end
    end

endmodule

// ===== hdl/triangle_counter.sv =====
// ----------------------------------------------------------------------------
// triangle_counter
// Edge-iterator triangle counter over an adjacency bit matrix.
// ----------------------------------------------------------------------------
// Edges load at one transfer per cycle: each edge sets one bit in the upper
// triangle of a MAX_VERTICES x MAX_VERTICES bit matrix held in a RAM of
// MAX_VERTICES rows (read-modify-write with forwarding, so back-to-back edges
// on the same row merge). Self-loops and out-of-range vertices set nothing.
// After the transfer marked last_edge the input stalls for the count pass,
// which for each row a reads that row and then every row b through the
// single RAM read port, and which also waits while the previous result is
// still held at the output. The result sits in an output register, so the
// next graph's edges load while it waits. Row valid bits clear the matrix
// at the result handoff; there is no clearing sweep.
// The count saturates at 65535.
// ----------------------------------------------------------------------------
module triangle_counter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [tc_pkg::IN_VW-1:0]   vertex_a,
    input  logic [tc_pkg::IN_VW-1:0]   vertex_b,
    input  logic                       last_edge,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [tc_pkg::COUNT_W-1:0] triangle_count
);

    import tc_pkg::*;

    tc_cmd_t cmd;
    tc_sts_t sts;

    tc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .last_edge (last_edge),
        .sts       (sts),
        .cmd       (cmd)
    );

    tc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .vertex_a       (vertex_a),
        .vertex_b       (vertex_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .triangle_count (triangle_count)
    );

endmodule

// ===== hdl/tc_checker.sv =====
// ----------------------------------------------------------------------------
// tc_checker
// Port-level checks for the triangle counter, bound to the top level.
// ----------------------------------------------------------------------------
module tc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       last_edge,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [tc_pkg::COUNT_W-1:0] triangle_count
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(triangle_count))
        else $error("result changed or dropped while stalled");

    // The input stalls right after the last edge transfer
    a_count_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_edge |=> in_stall)
        else $error("input not stalled after last edge");

    // Stall only starts on a last edge transfer
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall && last_edge))
        else $error("input stalled without a last edge");

    // A result only appears at the end of a count pass
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result produced outside a count pass");

endmodule

bind triangle_counter tc_checker u_tc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .last_edge      (last_edge),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .triangle_count (triangle_count)
);
